/* rtl/sprite_blit_clip_colour_key_top_assert.svh */
// Assertion macros shared by the sprite blitter RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef SPRITE_BLIT_CLIP_COLOUR_KEY_TOP_ASSERT_SVH
`define SPRITE_BLIT_CLIP_COLOUR_KEY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBCK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbck assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBCK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbck assertion failed");

`endif

/* rtl/sbck_pkg.sv */
// ----------------------------------------------------------------------------
// sbck_pkg
// Types and constants shared by the sprite blitter modules.
// ----------------------------------------------------------------------------
package sbck_pkg;

	localparam int COORD_W     = 10;
	localparam int PIX_W       = 16;
	localparam int ADDR_W      = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [PIX_W-1:0] KEY_RESET = 16'hFFFF;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_value;
		logic [COORD_W-1:0] sprite_height;
		logic [COORD_W-1:0] sprite_width;
		logic [COORD_W-1:0] y_origin;
		logic [COORD_W-1:0] x_origin;
	} sbck_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_value;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} sbck_entry_t;

endpackage

/* rtl/sbck_front.sv */
// ----------------------------------------------------------------------------
// sbck_front
// Accepts pixel words, tracks sprite geometry and position, and queues the
// on-screen, non-transparent pixels with their screen coordinates.
// ----------------------------------------------------------------------------
module sbck_front
	import sbck_pkg::*;
#(
	parameter int SCREEN_W = 240,
	parameter int SCREEN_H = 320
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_first,
	input  sbck_in_t         in_word,
	input  logic [PIX_W-1:0] transparent_colour,
	output logic             push_valid,
	input  logic             push_ready,
	output sbck_entry_t      push_entry
);

	`include "sprite_blit_clip_colour_key_top_assert.svh"

	logic [COORD_W-1:0] col_q, row_q, lx_q, ly_q, lw_q, lh_q;
	logic [COORD_W-1:0] col_e, row_e, lx_e, ly_e, lw_e, lh_e;
	logic [COORD_W:0]   x_sum, y_sum, col_inc;
	logic               live, emit, accept, wrap;

	always_comb begin
		if (in_first) begin
			lx_e  = in_word.x_origin;
			ly_e  = in_word.y_origin;
			lw_e  = (in_word.sprite_width == '0) ? COORD_W'(1) : in_word.sprite_width;
			lh_e  = (in_word.sprite_height == '0) ? COORD_W'(1) : in_word.sprite_height;
			col_e = '0;
			row_e = '0;
		end else begin
			lx_e  = lx_q;
			ly_e  = ly_q;
			lw_e  = lw_q;
			lh_e  = lh_q;
			col_e = col_q;
			row_e = row_q;
		end
		live    = row_e < lh_e;
		x_sum   = {1'b0, lx_e} + {1'b0, col_e};
		y_sum   = {1'b0, ly_e} + {1'b0, row_e};
		emit    = live && (x_sum < (COORD_W+1)'(SCREEN_W)) && (y_sum < (COORD_W+1)'(SCREEN_H))
			&& (in_word.pixel_value != transparent_colour);
		col_inc = {1'b0, col_e} + (COORD_W+1)'(1);
		wrap    = col_inc >= {1'b0, lw_e};
	end

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && emit;

	assign push_entry.x           = x_sum[COORD_W-1:0];
	assign push_entry.y           = y_sum[COORD_W-1:0];
	assign push_entry.pixel_value = in_word.pixel_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lx_q  <= '0;
			ly_q  <= '0;
			lw_q  <= COORD_W'(1);
			lh_q  <= COORD_W'(1);
		end else if (accept) begin
			lx_q <= lx_e;
			ly_q <= ly_e;
			lw_q <= lw_e;
			lh_q <= lh_e;
			if (!live) begin
				col_q <= col_e;
				row_q <= row_e;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_e + COORD_W'(1);
			end else begin
				col_q <= col_inc[COORD_W-1:0];
				row_q <= row_e;
			end
		end
	end

	`SBCK_ASSERT_SAME(a_row_bound, clk, arst_n, 1'b1, row_q <= lh_q)
	`SBCK_ASSERT_SAME(a_col_bound, clk, arst_n, 1'b1, col_q < lw_q)
	`SBCK_ASSERT_SAME(a_size_nonzero, clk, arst_n, 1'b1, (lw_q != '0) && (lh_q != '0))

endmodule

/* rtl/sbck_queue.sv */
// ----------------------------------------------------------------------------
// sbck_queue
// Short queue of pending framebuffer writes between the front and back parts.
// ----------------------------------------------------------------------------
module sbck_queue
	import sbck_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  sbck_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output sbck_entry_t pop_entry
);

	`include "sprite_blit_clip_colour_key_top_assert.svh"

	sbck_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`SBCK_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH))
	`SBCK_ASSERT_NEXT(a_push_only, clk, arst_n, do_push && !do_pop,
		count_q == $past(count_q) + QCNT_W'(1))
	`SBCK_ASSERT_SAME(a_ptr_track, clk, arst_n, count_q == '0 || count_q == QCNT_W'(QUEUE_DEPTH),
		wr_ptr_q == rd_ptr_q)

endmodule

/* rtl/sbck_back.sv */
// ----------------------------------------------------------------------------
// sbck_back
// Turns queued screen coordinates into linear framebuffer addresses and holds
// each write in an output register until it is taken.
// ----------------------------------------------------------------------------
module sbck_back
	import sbck_pkg::*;
#(
	parameter int SCREEN_W = 240
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  sbck_entry_t       pop_entry,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] out_address,
	output logic [PIX_W-1:0]  out_data
);

	localparam int PROD_W = 2 * COORD_W;

	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     sum;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PIX_W-1:0]    data_q;

	assign prod      = {{COORD_W{1'b0}}, pop_entry.y} * PROD_W'(SCREEN_W);
	assign sum       = {1'b0, prod} + (PROD_W+1)'(pop_entry.x);
	assign pop_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			addr_q <= sum[ADDR_W-1:0];
			data_q <= pop_entry.pixel_value;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = addr_q;
	assign out_data    = data_q;

endmodule

/* rtl/sprite_blit_clip_colour_key_top.sv */
// Sprite blitter with color-key transparency and right/bottom screen clipping.
// Pixel words are taken one per clock in row-major order; a word with tuser set
// starts a new sprite and carries its origin and size. Each pixel of a sprite that
// is on screen and differs from the transparent color produces one framebuffer
// write word. When the four-entry write queue is empty and the output register is
// free, the write is registered in the queue as the word is accepted, then in the
// output register that drives m_tvalid. The slave side accepts a word every cycle
// as long as that queue has room, so the sustained rate is one pixel per clock
// when the master side takes a write every cycle. The transparent color is written
// on the configuration channel, which is always ready, and resets to 0xFFFF.
// ----------------------------------------------------------------------------
// sprite_blit_clip_colour_key_top
// Top level: stream ports, transparent color register, front, queue, back.
// ----------------------------------------------------------------------------
module sprite_blit_clip_colour_key_top
	import sbck_pkg::*;
#(
	parameter int SCREEN_W = 240,
	parameter int SCREEN_H = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_origin[9:0], y_origin[19:10], sprite_width[29:20], sprite_height[39:30],
	// pixel_value[55:40]
	input  logic [55:0] s_tdata,
	// first_pixel[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// write_address[16:0], write_data[32:17], zero fill[39:33]
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [PIX_W-1:0]  key_q;
	sbck_in_t          in_word;
	sbck_entry_t       push_entry, pop_entry;
	logic              push_valid, push_ready, pop_valid, pop_ready;
	logic [ADDR_W-1:0] out_address;
	logic [PIX_W-1:0]  out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			key_q <= cfg_data;
		end
	end

	assign in_word = sbck_in_t'(s_tdata);

	sbck_front #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.in_first          (s_tuser),
		.in_word           (in_word),
		.transparent_colour(key_q),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_entry        (push_entry)
	);

	sbck_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	sbck_back #(
		.SCREEN_W(SCREEN_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_address(out_address),
		.out_data   (out_data)
	);

	assign m_tdata = {7'd0, out_data, out_address};

endmodule

/* bench/sprite_blit_clip_colour_key_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_blit_clip_colour_key_top_test
// Self-checking bench for the sprite blitter. Sprite pixel words are streamed
// in with random gaps, and the framebuffer writes are taken with random
// stalls. A software model tracks the latched geometry, the counters and the
// transparent color, and checks every write in order. A directed opening
// covers the reset geometry, zero sizes, clipping, off-screen origins and
// pixels past a sprite's end. Random phases then follow under several
// transparent colors, with one long hold-off on the write side.
// ----------------------------------------------------------------------------
module sprite_blit_clip_colour_key_top_test;
	import sbck_pkg::*;

	localparam int SCREEN_W       = 240;
	localparam int SCREEN_H       = 320;
	localparam int SETTLE_CYCLES  = 10;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SPRITE_PIX = 40;
	localparam int PHASE_ITEMS    = 250;
	localparam int NUM_PHASES     = 7;

	typedef struct {
		bit                 first;
		bit [COORD_W-1:0]   x;
		bit [COORD_W-1:0]   y;
		bit [COORD_W-1:0]   w;
		bit [COORD_W-1:0]   h;
		bit [PIX_W-1:0]     value;
	} pixel_word_t;

	typedef struct {
		bit [ADDR_W-1:0] address;
		bit [PIX_W-1:0]  colour;
	} fb_write_t;

	class blit_write_predictor;
		bit [PIX_W-1:0]   key;
		bit [COORD_W-1:0] col;
		bit [COORD_W-1:0] row;
		bit [COORD_W-1:0] org_x;
		bit [COORD_W-1:0] org_y;
		bit [COORD_W-1:0] span_w;
		bit [COORD_W-1:0] span_h;
		fb_write_t        pending_writes[$];
		int               mismatch_count;

		function new();
			key = 16'hFFFF;
			col = '0;
			row = '0;
			org_x = '0;
			org_y = '0;
			span_w = 10'd1;
			span_h = 10'd1;
			mismatch_count = 0;
		endfunction

		function void note_pixel(pixel_word_t p);
			int unsigned sx;
			int unsigned sy;
			fb_write_t   wr;
			if (p.first) begin
				org_x = p.x;
				org_y = p.y;
				span_w = (p.w == 0) ? 10'd1 : p.w;
				span_h = (p.h == 0) ? 10'd1 : p.h;
				col = '0;
				row = '0;
			end
			if (row >= span_h)
				return;
			sx = int'(org_x) + int'(col);
			sy = int'(org_y) + int'(row);
			if (sx < SCREEN_W && sy < SCREEN_H && p.value != key) begin
				wr.address = ADDR_W'(sx + sy * SCREEN_W);
				wr.colour = p.value;
				pending_writes.push_back(wr);
			end
			if (int'(col) + 1 >= int'(span_w)) begin
				col = '0;
				row = row + 1'b1;
			end else begin
				col = col + 1'b1;
			end
		endfunction

		function void check_write(bit [ADDR_W-1:0] address, bit [PIX_W-1:0] colour);
			fb_write_t want;
			if (pending_writes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected write address %0d data %h",
						$realtime, address, colour);
				return;
			end
			want = pending_writes.pop_front();
			if (want.address != address || want.colour != colour) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: expected addr %0d data %h, got addr %0d data %h",
						$realtime, want.address, want.colour, address, colour);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	blit_write_predictor predictor = new();
	bit [PIX_W-1:0] current_key = 16'hFFFF;
	bit             gaps_on = 1'b1;
	bit             hold_request = 1'b0;
	int             idle_cycles = 0;

	sprite_blit_clip_colour_key_top #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			predictor.check_write(m_tdata[16:0], m_tdata[32:17]);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sprite_blit_clip_colour_key_top_test: done, errors");
			$finish;
		end
	end

	// The write side normally stalls in short bursts; on request it holds off
	// long enough for the write queue to fill and the pixel side to stall.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic pixel_word_t make_word(bit first, bit [9:0] x, bit [9:0] y,
			bit [9:0] w, bit [9:0] h, bit [15:0] value);
		pixel_word_t p;
		p.first = first;
		p.x = x;
		p.y = y;
		p.w = w;
		p.h = h;
		p.value = value;
		return p;
	endfunction

	task automatic send_word(pixel_word_t p);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= p.first;
		s_tdata <= {p.value, p.h, p.w, p.y, p.x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predictor.note_pixel(p);
	endtask

	// Later pixels of a sprite carry random geometry, which the block must ignore.
	task automatic send_sprite(bit [9:0] x, bit [9:0] y, bit [9:0] w, bit [9:0] h,
			int count, int key_percent);
		bit [15:0] value;
		for (int i = 0; i < count; i++) begin
			value = 16'($urandom);
			if (value == current_key)
				value ^= 16'h0001;
			if ($urandom_range(0, 99) < key_percent)
				value = current_key;
			if (i == 0)
				send_word(make_word(1'b1, x, y, w, h, value));
			else
				send_word(make_word(1'b0, 10'($urandom), 10'($urandom), 10'($urandom),
					10'($urandom), value));
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (predictor.pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(bit [15:0] key);
		cfg_valid <= 1'b1;
		cfg_data <= key;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		predictor.key = key;
		current_key = key;
	endtask

	task automatic run_random(int items);
		int sent;
		int pick;
		int eff_w;
		int eff_h;
		int count;
		bit [9:0] x;
		bit [9:0] y;
		bit [9:0] w;
		bit [9:0] h;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				x = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 250));
				y = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 330));
				w = 10'($urandom_range(1, 8));
				h = 10'($urandom_range(1, 6));
				if (pick < 6) begin
					w = 10'($urandom);
					h = 10'($urandom_range(1, 2));
				end
				if ($urandom_range(0, 19) == 0)
					w = '0;
				if ($urandom_range(0, 19) == 0)
					h = '0;
				eff_w = (w == 0) ? 1 : int'(w);
				eff_h = (h == 0) ? 1 : int'(h);
				count = eff_w * eff_h;
				if (count > MAX_SPRITE_PIX)
					count = MAX_SPRITE_PIX;
				send_sprite(x, y, w, h, count, 20);
				sent += count;
			end else if (pick < 90) begin
				count = $urandom_range(1, 5);
				send_sprite(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
					count, 20);
				sent += count;
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(make_word(1'b0, 10'($urandom), 10'($urandom),
						10'($urandom), 10'($urandom),
						($urandom_range(0, 4) == 0) ? current_key : 16'($urandom)));
			end
		end
	endtask

	initial begin
		bit [15:0] keys[NUM_PHASES];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no sprite started, the reset geometry is a 1x1 sprite at the origin.
		send_word(make_word(1'b0, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'h1234));
		send_word(make_word(1'b0, 10'h000, 10'h000, 10'h000, 10'h000, 16'hABCD));
		// A zero size is taken as one, here at the last screen position.
		send_word(make_word(1'b1, 10'd239, 10'd319, 10'd0, 10'd0, 16'h0000));
		send_word(make_word(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0001));
		send_sprite(10'd238, 10'd318, 10'd3, 10'd3, 9, 30);
		send_sprite(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 2, 0);
		send_sprite(10'd240, 10'd0, 10'd2, 10'd1, 2, 0);
		send_sprite(10'd0, 10'd320, 10'd1, 10'd1, 1, 0);
		send_word(make_word(1'b1, 10'd0, 10'd0, 10'h3FF, 10'd1, 16'hFFFE));
		send_word(make_word(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000));
		send_word(make_word(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF));
		settle();

		write_key(16'h0000);
		send_word(make_word(1'b1, 10'd5, 10'd5, 10'd2, 10'd2, 16'h0000));
		send_word(make_word(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF));
		send_word(make_word(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000));
		send_word(make_word(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0001));
		settle();

		keys[0] = 16'($urandom);
		keys[1] = 16'hFFFF;
		keys[2] = 16'($urandom);
		keys[3] = 16'h0000;
		keys[4] = 16'h5A5A;
		keys[5] = 16'($urandom);
		keys[6] = 16'($urandom);
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			gaps_on = (phase != 3) && (phase < NUM_PHASES - 1);
			write_key(keys[phase]);
			if (phase == 1) begin
				hold_request = 1'b1;
				send_sprite(10'd10, 10'd10, 10'd8, 10'd8, 64, 0);
			end
			run_random(PHASE_ITEMS);
			settle();
		end

		if (predictor.mismatch_count == 0 && predictor.pending_writes.size() == 0)
			$display("sprite_blit_clip_colour_key_top_test: done, clean");
		else
			$display("sprite_blit_clip_colour_key_top_test: done, errors");
		$finish;
	end

endmodule
